@@ rtl/rppp_pkg.sv @@
package rppp_pkg;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_STORE = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_ZERO  = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    localparam int DIV_BITS = 48;
    localparam int CNT_W    = 6;

    typedef struct packed {
        logic [8:0]  r0;
        logic [8:0]  r1;
        logic [9:0]  c0;
        logic [9:0]  c1;
        logic [31:0] colour;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] w;
    } filt_t;

    typedef struct packed {
        logic        func;
        logic [8:0]  row;
        logic [9:0]  col;
        logic [31:0] colour;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        nan;
        logic        skip;
        logic [CNT_W-1:0] cnt;
        logic        sat;
        logic        zero;
        logic [2:0]  status;
    } pt_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 output logic s);
        if (v > 66'sd2147483647)
        begin
            s = 1'b1;
            sat32 = 32'sh7fffffff;
        end
        else if (v < -66'sd2147483648)
        begin
            s = 1'b1;
            sat32 = 32'sh80000000;
        end
        else
        begin
            s = 1'b0;
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                output logic s);
        logic signed [63:0] p;
        p = a * b;
        qmul = sat32({{18{p[63]}}, p[63:16]}, s);
    endfunction

endpackage

@@ rtl/rppp_stage.sv @@
module rppp_stage
    import rppp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  pt_t   in_pt,
    input  logic  active,
    input  filt_t filt,
    output logic  out_valid,
    output pt_t   out_pt
);

    localparam int NB = DIV_BITS;

    // Stage A registers the products and stage B the saturated dot product.
    // The next stage loads the divider, NB restoring steps follow, and the
    // last stage registers the scaled point.
    logic [NB+3:0] v_reg;
    pt_t p_reg [NB+4];
    logic hit_reg [NB+4];
    logic signed [31:0] qx_reg, qy_reg, qz_reg;
    logic signed [31:0] dot_reg;
    logic signed [31:0] w_reg [NB+4];
    logic [NB-1:0] rem_reg [NB+4];
    logic [NB-1:0] quo_reg [NB+4];
    logic [31:0] dv_reg [NB+4];
    logic neg_reg [NB+4];

    logic hit;
    logic s0, s1, s2, sd, sq, sx, sy, sz;
    logic signed [31:0] a0, a1, a2, dotv, scale;
    logic signed [65:0] dsum;
    logic signed [NB:0] qs;

    assign hit = active && in_pt.func == 1'b0 && !in_pt.skip
        && in_pt.row >= filt.r0 && in_pt.row <= filt.r1
        && in_pt.col >= filt.c0 && in_pt.col <= filt.c1;

    always_comb
    begin
        a0 = qmul(in_pt.x, filt.nx, s0);
        a1 = qmul(in_pt.y, filt.ny, s1);
        a2 = qmul(in_pt.z, filt.nz, s2);
        dsum = 66'(qx_reg) + 66'(qy_reg) + 66'(qz_reg);
        dotv = sat32(dsum, sd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NB+2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= in_pt;
            hit_reg[0] <= hit;
            w_reg[0] <= filt.w;
            if (hit)
            begin
                p_reg[0].colour <= filt.colour;
                p_reg[0].sat <= in_pt.sat | s0 | s1 | s2;
            end
            qx_reg <= a0;
            qy_reg <= a1;
            qz_reg <= a2;
            p_reg[1] <= p_reg[0];
            hit_reg[1] <= hit_reg[0];
            w_reg[1] <= w_reg[0];
            dot_reg <= dotv;
            if (hit_reg[0])
            begin
                p_reg[1].sat <= p_reg[0].sat | sd;
                if (dotv == 32'sd0)
                begin
                    p_reg[1].zero <= 1'b1;
                    hit_reg[1] <= 1'b0;
                end
            end
            // load divider
            p_reg[2] <= p_reg[1];
            hit_reg[2] <= hit_reg[1];
            w_reg[2] <= w_reg[1];
            neg_reg[2] <= w_reg[1][31] ^ dot_reg[31];
            rem_reg[2] <= '0;
            quo_reg[2] <= NB'({w_reg[1][31] ? -33'(w_reg[1]) : 33'(w_reg[1]), 16'd0});
            dv_reg[2] <= dot_reg[31] ? 32'(-33'(dot_reg)) : 32'(dot_reg);
            for (int i = 3; i < NB + 3; i++)
            begin
                logic [NB:0] r;
                r = {rem_reg[i-1], quo_reg[i-1][NB-1]};
                p_reg[i] <= p_reg[i-1];
                hit_reg[i] <= hit_reg[i-1];
                w_reg[i] <= w_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                dv_reg[i] <= dv_reg[i-1];
                if (r >= (NB+1)'(dv_reg[i-1]))
                begin
                    rem_reg[i] <= NB'(r - (NB+1)'(dv_reg[i-1]));
                    quo_reg[i] <= {quo_reg[i-1][NB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= NB'(r);
                    quo_reg[i] <= {quo_reg[i-1][NB-2:0], 1'b0};
                end
            end
            p_reg[NB+3] <= p_reg[NB+2];
            if (hit_reg[NB+2])
            begin
                p_reg[NB+3].x <= qmul(p_reg[NB+2].x, scale, sx);
                p_reg[NB+3].y <= qmul(p_reg[NB+2].y, scale, sy);
                p_reg[NB+3].z <= qmul(p_reg[NB+2].z, scale, sz);
                p_reg[NB+3].sat <= p_reg[NB+2].sat | sq | sx | sy | sz;
            end
        end
    end

    always_comb
    begin
        qs = neg_reg[NB+2] ? -(NB+1)'(quo_reg[NB+2]) : (NB+1)'(quo_reg[NB+2]);
        scale = sat32(66'(qs), sq);
    end

    assign out_valid = v_reg[NB+3];
    assign out_pt = p_reg[NB+3];

endmodule

@@ rtl/region_plane_point_projector_top.sv @@
// Channel   | Direction | tdata                        | tuser
// s_axis    | in        | point or filter fields       | func, is_nan
// m_axis    | out       | x_out, y_out, z_out, colour  | nan_out, status
// One transaction can enter per cycle while m_axis is not stalled. Each of the MAX_FILTERS
// filter slots runs a divider that takes one long-division step per cycle, and the slots
// are chained so that every result passes through each slot in order.
// rst_n clears the valid bits and the filter count; the filter table is not reset.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
module region_plane_point_projector_top
    import rppp_pkg::*;
#(
    parameter int MAX_FILTERS  = 8,
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // row_a, row_b, col_a, col_b, colour, val_x, val_y, val_z, val_w
    input  logic [199:0] s_axis_tdata,
    // func, is_nan
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // x_out, y_out, z_out, colour_out
    output logic [127:0] m_axis_tdata,
    // nan_out, status
    output logic [3:0]   m_axis_tuser
);

    localparam int CW = $clog2(MAX_FILTERS + 1);
    localparam int IW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int NL = MAX_FILTERS + 1;

    filt_t filt_reg [MAX_FILTERS];
    logic [CW-1:0] count_reg;
    logic en, acc, room, load;
    logic [NL-1:0] v;
    pt_t p [NL];
    pt_t in_pt;
    logic inimg;
    logic [2:0] st_o;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign room = 32'(count_reg) < MAX_FILTERS;
    assign load = acc && s_axis_tuser[0] && room;

    assign inimg = 32'(s_axis_tdata[8:0]) < IMAGE_HEIGHT
        && 32'(s_axis_tdata[27:18]) < IMAGE_WIDTH;

    always_comb
    begin
        in_pt.func = s_axis_tuser[0];
        in_pt.row = s_axis_tdata[8:0];
        in_pt.col = s_axis_tdata[27:18];
        in_pt.colour = s_axis_tdata[69:38];
        in_pt.x = s_axis_tdata[101:70];
        in_pt.y = s_axis_tdata[133:102];
        in_pt.z = s_axis_tdata[165:134];
        in_pt.nan = s_axis_tuser[1];
        in_pt.skip = s_axis_tuser[1] | !inimg;
        in_pt.cnt = CNT_W'(count_reg);
        in_pt.sat = 1'b0;
        in_pt.zero = 1'b0;
        in_pt.status = ST_OK;
        if (s_axis_tuser[0])
        begin
            in_pt.x = '0;
            in_pt.y = '0;
            in_pt.z = '0;
            in_pt.colour = '0;
            in_pt.nan = 1'b0;
            in_pt.status = room ? ST_STORE : ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            filt_reg[count_reg[IW-1:0]] <=
                '{r0: s_axis_tdata[8:0], r1: s_axis_tdata[17:9],
                  c0: s_axis_tdata[27:18], c1: s_axis_tdata[37:28],
                  colour: s_axis_tdata[69:38], nx: s_axis_tdata[101:70],
                  ny: s_axis_tdata[133:102], nz: s_axis_tdata[165:134],
                  w: s_axis_tdata[197:166]};
        end
    end

    assign v[0] = acc;
    assign p[0] = in_pt;

    genvar g;
    generate
        for (g = 0; g < MAX_FILTERS; g++)
        begin : g_st
            rppp_stage u_st (
                .clk(clk), .rst_n(rst_n), .en(en),
                .in_valid(v[g]), .in_pt(p[g]),
                .active(32'(p[g].cnt) > g), .filt(filt_reg[g]),
                .out_valid(v[g+1]), .out_pt(p[g+1])
            );
        end
    endgenerate

    assign st_o = p[MAX_FILTERS].func ? p[MAX_FILTERS].status
        : (p[MAX_FILTERS].zero ? ST_ZERO : (p[MAX_FILTERS].sat ? ST_SAT : ST_OK));

    assign m_axis_tvalid = v[MAX_FILTERS];
    assign m_axis_tdata = {p[MAX_FILTERS].colour, p[MAX_FILTERS].z,
        p[MAX_FILTERS].y, p[MAX_FILTERS].x};
    assign m_axis_tuser = {st_o, p[MAX_FILTERS].nan};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_FILTERS);

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[3:1] <= ST_SAT);

    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && p[MAX_FILTERS].func |-> m_axis_tdata == '0 && !m_axis_tuser[0]);

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready);

endmodule
